FILE: rtl/mab_pkg.sv
// Shared types, constants and helpers for the masked alpha blend pixel block.
// Used by mab_mask, masked_alpha_blend_pixel and the testbench; depends on nothing.

package mab_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_MASK_MODE       = 2'd0;
   localparam logic [1:0] CSR_CORNER_FRACTION = 2'd1;
   localparam logic [1:0] CSR_OPACITY         = 2'd2;

   // Fixed-point constants.
   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam logic [15:0] HALF_Q16     = 16'd32768;
   localparam logic [23:0] ALPHA_ROUND  = 24'd32768;
   localparam logic [7:0]  CHAN_MAX     = 8'd255;
   localparam logic [15:0] MIX_ROUND    = 16'd127;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [32:0] CIRCLE_LIMIT = 33'h1_0000_0000;

   // Mask shapes. The unused code behaves as no mask.
   typedef enum logic [1:0] {
      MASK_NONE    = 2'd0,
      MASK_CIRCLE  = 2'd1,
      MASK_ROUNDED = 2'd2
   } mask_mode_type;

   // Mask settings handed to the coverage unit.
   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] radius;   // corner radius, already clamped to one half
   } mask_cfg_type;

   // Exact floor(x / 255) for the blend sums, which stay below 65408.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

FILE: rtl/mab_mask.sv
// Shape mask coverage unit: three register stages from position to covered flag.
// Depends on mab_pkg for the mask mode codes and the settings struct.

module mab_mask (
   input  logic                  clock,
   input  mab_pkg::mask_cfg_type cfg,
   input  logic signed [18:0]    mask_u,
   input  logic signed [18:0]    mask_v,
   output logic                  covered
);

   localparam logic signed [20:0] ONE_S = 21'sd65536;

   mab_pkg::mask_mode_type kind1_ff, kind1_in, kind2_ff;
   logic signed [20:0] du1_ff, du1_in, dv1_ff, dv1_in;
   logic [15:0]        radius1_ff;
   logic [39:0]        squ2_ff, squ2_in, sqv2_ff, sqv2_in;
   logic [32:0]        limit2_ff, limit2_in;
   logic               covered3_ff, covered3_in;

   logic signed [20:0] u_w, v_w, r_w, far_w;
   logic signed [20:0] ru_w, ur_w, rv_w, vr_w;
   logic signed [41:0] pu_w, pv_w;
   logic [40:0]        dist_w;

   // Stage 1: offsets from the circle center or from the rounded corner.
   always_comb begin
      u_w   = 21'(mask_u);
      v_w   = 21'(mask_v);
      r_w   = signed'({5'd0, cfg.radius});
      far_w = ONE_S - r_w;
      ru_w  = r_w - u_w;
      ur_w  = u_w - far_w;
      rv_w  = r_w - v_w;
      vr_w  = v_w - far_w;
      du1_in = '0;
      dv1_in = '0;
      unique case (cfg.mode)
         mab_pkg::MASK_CIRCLE: begin
            kind1_in = mab_pkg::MASK_CIRCLE;
            du1_in   = (u_w <<< 1) - ONE_S;
            dv1_in   = (v_w <<< 1) - ONE_S;
         end
         mab_pkg::MASK_ROUNDED: begin
            kind1_in = mab_pkg::MASK_ROUNDED;
            if (ru_w > du1_in) du1_in = ru_w;
            if (ur_w > du1_in) du1_in = ur_w;
            if (rv_w > dv1_in) dv1_in = rv_w;
            if (vr_w > dv1_in) dv1_in = vr_w;
         end
         default: begin
            kind1_in = mab_pkg::MASK_NONE;
         end
      endcase
   end

   // Stage 2: squared offsets and the squared radius to compare against.
   always_comb begin
      pu_w    = du1_ff * du1_ff;
      pv_w    = dv1_ff * dv1_ff;
      squ2_in = pu_w[39:0];
      sqv2_in = pv_w[39:0];
      if (kind1_ff == mab_pkg::MASK_CIRCLE) begin
         limit2_in = mab_pkg::CIRCLE_LIMIT;
      end else begin
         limit2_in = {1'b0, 32'(radius1_ff * radius1_ff)};
      end
   end

   // Stage 3: the distance test.
   always_comb begin
      dist_w      = {1'b0, squ2_ff} + {1'b0, sqv2_ff};
      covered3_in = (kind2_ff == mab_pkg::MASK_NONE) || (dist_w <= {8'd0, limit2_ff});
   end

   always_ff @(posedge clock) begin
      kind1_ff    <= kind1_in;
      du1_ff      <= du1_in;
      dv1_ff      <= dv1_in;
      radius1_ff  <= cfg.radius;
      kind2_ff    <= kind1_ff;
      squ2_ff     <= squ2_in;
      sqv2_ff     <= sqv2_in;
      limit2_ff   <= limit2_in;
      covered3_ff <= covered3_in;
   end

   assign covered = covered3_ff;

endmodule

FILE: rtl/masked_alpha_blend_pixel.sv
// Top level of the masked source-over alpha blend pixel block.
// Depends on mab_pkg and instantiates the coverage unit mab_mask.

// A request carries one straight-alpha source pixel, one RGB destination pixel
// and the pixel center's position in the mask box (Q2.16). A request is taken
// at each rising edge where start is high and busy is low; busy is high only
// while reset is held, so one request can enter every clock cycle.
// Each request gives exactly one result: rsp_strobe is high for one cycle with
// rsp_out_pixel and rsp_write_enable, in request order.
// The receiver cannot hold results off, and the block never needs to.
// Throughput is one pixel per cycle while reset is low. The four register stages
// are offsets and scaled alpha, squares and channel products, distance test and
// division by 255, then the output register.
// The csr_ port writes one of mask mode, corner fraction or opacity, chosen by csr_index;
// write it only while no request is in flight.
// Reset clears the pipeline valid bits and restores mask mode none,
// corner fraction zero and full opacity.

module masked_alpha_blend_pixel (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_src_pixel,
   input  logic [23:0]        req_dst_pixel,
   input  logic signed [18:0] req_mask_u,
   input  logic signed [18:0] req_mask_v,
   output logic               rsp_strobe,
   output logic [31:0]        rsp_out_pixel,
   output logic               rsp_write_enable,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_write_data
);

   logic [1:0]  mask_mode_ff;
   logic [15:0] corner_fraction_ff;
   logic [16:0] opacity_ff;

   logic [16:0]           opacity_sat_w;
   mab_pkg::mask_cfg_type mask_cfg_w;
   logic                  accept_w;
   logic                  covered_w;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [23:0] src1_ff, dst1_ff;
   logic [7:0]  b1_ff, b1_in;
   logic [24:0] alpha_prod_w;
   logic [15:0] x2_ff [3];
   logic [15:0] x2_in [3];
   logic        cand2_ff, cand3_ff;
   logic [7:0]  q3_ff [3];
   logic [7:0]  q3_in [3];
   logic [31:0] out4_ff, out4_in;
   logic        we4_ff, we4_in;

   assign busy     = reset;
   assign accept_w = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_mode_ff       <= mab_pkg::MASK_NONE;
         corner_fraction_ff <= '0;
         opacity_ff         <= mab_pkg::ONE_Q16;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mab_pkg::CSR_MASK_MODE:       mask_mode_ff       <= csr_write_data[1:0];
            mab_pkg::CSR_CORNER_FRACTION: corner_fraction_ff <= csr_write_data[15:0];
            mab_pkg::CSR_OPACITY:         opacity_ff         <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Saturate opacity to one and the corner radius to one half.
   always_comb begin
      opacity_sat_w   = (opacity_ff > mab_pkg::ONE_Q16) ? mab_pkg::ONE_Q16 : opacity_ff;
      mask_cfg_w.mode = mask_mode_ff;
      mask_cfg_w.radius = (corner_fraction_ff > mab_pkg::HALF_Q16) ?
                          mab_pkg::HALF_Q16 : corner_fraction_ff;
   end

   mab_mask u_mask (
      .clock   (clock),
      .cfg     (mask_cfg_w),
      .mask_u  (req_mask_u),
      .mask_v  (req_mask_v),
      .covered (covered_w)
   );

   // Stage 1: source alpha scaled by opacity, rounding halves up.
   always_comb begin
      alpha_prod_w = 25'(opacity_sat_w * req_src_pixel[31:24]) + 25'(mab_pkg::ALPHA_ROUND);
      b1_in        = alpha_prod_w[23:16];
   end

   // Stage 2: per-channel weighted sums with the rounding term.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         x2_in[c] = 16'(src1_ff[8*c +: 8] * b1_ff)
                  + 16'(dst1_ff[8*c +: 8] * (mab_pkg::CHAN_MAX - b1_ff))
                  + mab_pkg::MIX_ROUND;
      end
   end

   // Stage 3: division by 255.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         q3_in[c] = mab_pkg::div255(x2_ff[c]);
      end
   end

   // Stage 4: join coverage with the blend and form the result.
   always_comb begin
      we4_in  = v3_ff && cand3_ff && covered_w;
      out4_in = we4_in ? {mab_pkg::ALPHA_OPAQUE, q3_ff[2], q3_ff[1], q3_ff[0]} : '0;
   end

   // Data registers of the pipeline.
   always_ff @(posedge clock) begin
      src1_ff  <= req_src_pixel[23:0];
      dst1_ff  <= req_dst_pixel;
      b1_ff    <= b1_in;
      x2_ff    <= x2_in;
      cand2_ff <= (b1_ff != 8'd0);
      q3_ff    <= q3_in;
      cand3_ff <= cand2_ff;
      out4_ff  <= out4_in;
   end

   // Valid bits and the write flag travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         we4_ff <= 1'b0;
      end else begin
         v1_ff  <= accept_w;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         we4_ff <= we4_in;
      end
   end

   assign rsp_strobe       = v4_ff;
   assign rsp_out_pixel    = out4_ff;
   assign rsp_write_enable = we4_ff;

   // Every accepted request yields one result on rsp_strobe.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(accept_w, 4))
      else $error("result strobe does not match a request four cycles earlier");

   // A write is only flagged on a delivered result, and it is always opaque.
   a_write_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_write_enable |-> (rsp_strobe && rsp_out_pixel[31:24] == mab_pkg::ALPHA_OPAQUE))
      else $error("write flag without a strobe or with a non-opaque pixel");

   // A result that does not write carries a zero pixel.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_write_enable) |-> (rsp_out_pixel == 32'd0))
      else $error("result without write carries a nonzero pixel");

endmodule

FILE: dv/tb_masked_alpha_blend_pixel.sv
// Self-checking testbench for masked_alpha_blend_pixel: directed table, then random phases.
// Depends on mab_pkg and the RTL top; results are checked against typed-in expectations or a local blend predictor.

module tb_masked_alpha_blend_pixel;

   localparam longint Q16_ONE  = 65536;
   localparam longint Q16_HALF = 32768;
   localparam logic [1:0] MASK_NONE    = mab_pkg::MASK_NONE;
   localparam logic [1:0] MASK_CIRCLE  = mab_pkg::MASK_CIRCLE;
   localparam logic [1:0] MASK_ROUNDED = mab_pkg::MASK_ROUNDED;
   localparam logic [1:0] MASK_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 85;
   localparam int DIRECTED_ROWS = 26;

   // One expected result.
   typedef struct packed {
      logic [31:0] pixel;
      logic        we;
   } blend_result_type;

   // One directed request with the register settings it runs under.
   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        corner;
      logic [16:0]        opacity;
      logic [31:0]        src;
      logic [23:0]        dst;
      logic signed [18:0] u;
      logic signed [18:0] v;
      logic               known;
      logic [31:0]        exp_pixel;
      logic               exp_we;
   } pixel_case_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [31:0]        req_src_pixel = '0;
   logic [23:0]        req_dst_pixel = '0;
   logic signed [18:0] req_mask_u = '0;
   logic signed [18:0] req_mask_v = '0;
   logic               rsp_strobe;
   logic [31:0]        rsp_out_pixel;
   logic               rsp_write_enable;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [16:0]        csr_write_data = '0;

   // Expectation that travels with a directed request whose result is typed in.
   logic               req_known = 1'b0;
   logic [31:0]        req_exp_pixel = '0;
   logic               req_exp_we = 1'b0;

   // Register copy seen by the predictor.
   logic [1:0]  cfg_mask_mode = MASK_NONE;
   logic [15:0] cfg_corner = '0;
   logic [16:0] cfg_opacity = 17'd65536;

   // Settings currently driven by the stimulus.
   logic [1:0]  drv_mode = MASK_NONE;
   logic [15:0] drv_corner = '0;
   logic [16:0] drv_opacity = 17'd65536;

   blend_result_type blend_expect_q[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   pixel_case_type   directed_cases [DIRECTED_ROWS];

   masked_alpha_blend_pixel dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_src_pixel    (req_src_pixel),
      .req_dst_pixel    (req_dst_pixel),
      .req_mask_u       (req_mask_u),
      .req_mask_v       (req_mask_v),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_write_enable (rsp_write_enable),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Distance outside the straight part of a rounded box along one axis.
   function automatic longint corner_reach(input longint p, input longint r);
      longint d;
      d = 0;
      if (r - p > d) d = r - p;
      if (p - (Q16_ONE - r) > d) d = p - (Q16_ONE - r);
      return d;
   endfunction

   // Source over destination for one channel, rounded division by 255.
   function automatic logic [7:0] mix_channel(input longint s, input longint d, input longint b);
      longint t;
      t = (s * b + d * (255 - b) + 127) / 255;
      return t[7:0];
   endfunction

   // Expected result of one request under the given register settings.
   function automatic blend_result_type predict_blend(
      input logic [31:0] src, input logic [23:0] dst,
      input logic signed [18:0] u_q, input logic signed [18:0] v_q,
      input logic [1:0] mode, input logic [15:0] corner, input logic [16:0] opacity_q);
      longint u, v, du, dv, r, dx, dy, op, alpha, b;
      bit covered;
      blend_result_type res;
      u = u_q;
      v = v_q;
      res = '0;
      case (mode)
         MASK_CIRCLE: begin
            du = 2 * u - Q16_ONE;
            dv = 2 * v - Q16_ONE;
            covered = (du * du + dv * dv <= Q16_ONE * Q16_ONE);
         end
         MASK_ROUNDED: begin
            r = corner;
            if (r > Q16_HALF) r = Q16_HALF;
            dx = corner_reach(u, r);
            dy = corner_reach(v, r);
            covered = (dx * dx + dy * dy <= r * r);
         end
         default: covered = 1'b1;
      endcase
      op = opacity_q;
      if (op > Q16_ONE) op = Q16_ONE;
      alpha = src[31:24];
      if (op != 0 && covered && alpha != 0) begin
         b = (op * alpha + Q16_HALF) >> 16;
         if (b > 255) b = 255;
         if (b != 0) begin
            res.pixel = {8'hFF, mix_channel(src[23:16], dst[23:16], b),
                         mix_channel(src[15:8], dst[15:8], b),
                         mix_channel(src[7:0], dst[7:0], b)};
            res.we = 1'b1;
         end
      end
      return res;
   endfunction

   // Results are checked, accepted requests are predicted, and register writes are mirrored.
   always @(posedge clock) begin
      blend_result_type want;
      if (reset) begin
         cfg_mask_mode = MASK_NONE;
         cfg_corner = '0;
         cfg_opacity = 17'd65536;
      end else begin
         if (rsp_strobe) begin
            if (blend_expect_q.size() == 0) begin
               $error("unexpected result: out_pixel %h write_enable %b",
                      rsp_out_pixel, rsp_write_enable);
               mismatch_count++;
            end else begin
               want = blend_expect_q.pop_front();
               if (rsp_out_pixel !== want.pixel) begin
                  $error("out_pixel mismatch: expected %h, actual %h", want.pixel, rsp_out_pixel);
                  mismatch_count++;
               end
               if (rsp_write_enable !== want.we) begin
                  $error("write_enable mismatch: expected %b, actual %b",
                         want.we, rsp_write_enable);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_known)
               blend_expect_q.push_back('{req_exp_pixel, req_exp_we});
            else
               blend_expect_q.push_back(predict_blend(req_src_pixel, req_dst_pixel,
                  req_mask_u, req_mask_v, cfg_mask_mode, cfg_corner, cfg_opacity));
         end
         if (csr_write_enable) begin
            case (csr_index)
               mab_pkg::CSR_MASK_MODE:       cfg_mask_mode = csr_write_data[1:0];
               mab_pkg::CSR_CORNER_FRACTION: cfg_corner = csr_write_data[15:0];
               mab_pkg::CSR_OPACITY:         cfg_opacity = csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL masked_alpha_blend_pixel");
         $finish;
      end
   end

   // Idle gap before the next request: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mask coordinate, mostly around the box, sometimes anywhere, sometimes on a box edge, the center or a range limit.
   function automatic logic signed [18:0] pick_coord();
      int r;
      int val;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         val = int'($urandom_range(0, 81920)) - 8192;
      end else if (r < 85) begin
         val = int'($urandom_range(0, 262144)) - 131072;
      end else begin
         case ($urandom_range(0, 4))
            0: val = -131072;
            1: val = 131072;
            2: val = 0 + int'($urandom_range(0, 4)) - 2;
            3: val = 32768 + int'($urandom_range(0, 4)) - 2;
            default: val = 65536 + int'($urandom_range(0, 4)) - 2;
         endcase
      end
      return val[18:0];
   endfunction

   // Drive one request and hold it until it is taken.
   task automatic send_pixel(input logic [31:0] src, input logic [23:0] dst,
                             input logic signed [18:0] u, input logic signed [18:0] v,
                             input logic known, input logic [31:0] exp_pixel,
                             input logic exp_we, input int gap);
      req_src_pixel <= src;
      req_dst_pixel <= dst;
      req_mask_u <= u;
      req_mask_v <= v;
      req_known <= known;
      req_exp_pixel <= exp_pixel;
      req_exp_we <= exp_we;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop issuing and wait until every expected result has come back.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (blend_expect_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [16:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Load a full register setting while the block is idle.
   task automatic apply_config(input logic [1:0] mode, input logic [15:0] corner,
                               input logic [16:0] opacity_q);
      drain_pipeline();
      write_register(mab_pkg::CSR_MASK_MODE, {15'd0, mode});
      write_register(mab_pkg::CSR_CORNER_FRACTION, {1'b0, corner});
      write_register(mab_pkg::CSR_OPACITY, opacity_q);
      drv_mode = mode;
      drv_corner = corner;
      drv_opacity = opacity_q;
   endtask

   initial begin
      pixel_case_type row;
      logic [1:0]  mode;
      logic [15:0] corner;
      logic [16:0] opacity_q;
      logic [31:0] src;
      bit          burst;
      int          pick;

      directed_cases = '{
         // Reset settings: opaque white, transparent source, full cover without a mask.
         '{MASK_NONE, 16'd0, 17'd65536, 32'hFFFFFFFF, 24'h000000, 19'sd0, 19'sd0,
           1'b1, 32'hFFFFFFFF, 1'b1},
         '{MASK_NONE, 16'd0, 17'd65536, 32'h00123456, 24'hFFFFFF, 19'sd0, 19'sd0,
           1'b1, 32'h00000000, 1'b0},
         '{MASK_NONE, 16'd0, 17'd65536, 32'hFF000000, 24'hFFFFFF, -19'sd131072, 19'sd131072,
           1'b1, 32'hFF000000, 1'b1},
         '{MASK_NONE, 16'd0, 17'd65536, 32'h80FF8040, 24'h204060, 19'sd100, 19'sd200,
           1'b0, 32'h0, 1'b0},
         '{MASK_NONE, 16'd0, 17'd65536, 32'h01FFFFFF, 24'h000000, 19'sd0, 19'sd0,
           1'b0, 32'h0, 1'b0},
         '{MASK_NONE, 16'd0, 17'd65536, 32'h00000000, 24'hFFFFFF, 19'sd65536, 19'sd65536,
           1'b1, 32'h00000000, 1'b0},
         // The unused mask code covers everything.
         '{MASK_UNUSED, 16'd0, 17'd65536, 32'hFF0A0B0C, 24'h5A5A5A, -19'sd131072, -19'sd131072,
           1'b1, 32'hFF0A0B0C, 1'b1},
         // Zero opacity, alpha that rounds to zero, saturating opacity, partial opacity.
         '{MASK_NONE, 16'd0, 17'd0, 32'hFFFFFFFF, 24'h000000, 19'sd32768, 19'sd32768,
           1'b1, 32'h00000000, 1'b0},
         '{MASK_NONE, 16'd0, 17'd1, 32'hFFFFFFFF, 24'h000000, 19'sd32768, 19'sd32768,
           1'b1, 32'h00000000, 1'b0},
         '{MASK_NONE, 16'd0, 17'd32768, 32'h01FFFFFF, 24'h000000, 19'sd0, 19'sd0,
           1'b0, 32'h0, 1'b0},
         '{MASK_NONE, 16'd0, 17'd131071, 32'hFF112233, 24'h445566, 19'sd0, 19'sd0,
           1'b1, 32'hFF112233, 1'b1},
         '{MASK_NONE, 16'd0, 17'd49152, 32'h7FC0C0C0, 24'h102030, 19'sd0, 19'sd0,
           1'b0, 32'h0, 1'b0},
         // Inscribed circle: center, box corner, edge points, far outside.
         '{MASK_CIRCLE, 16'd0, 17'd65536, 32'hFF808080, 24'h000000, 19'sd32768, 19'sd32768,
           1'b1, 32'hFF808080, 1'b1},
         '{MASK_CIRCLE, 16'd0, 17'd65536, 32'hFFFFFFFF, 24'h000000, 19'sd0, 19'sd0,
           1'b1, 32'h00000000, 1'b0},
         '{MASK_CIRCLE, 16'd0, 17'd65536, 32'hC0204080, 24'hFFFFFF, 19'sd0, 19'sd32768,
           1'b0, 32'h0, 1'b0},
         '{MASK_CIRCLE, 16'd0, 17'd65536, 32'hC0204080, 24'hFFFFFF, 19'sd65536, 19'sd32768,
           1'b0, 32'h0, 1'b0},
         '{MASK_CIRCLE, 16'd0, 17'd65536, 32'hFFFFFFFF, 24'h000000, -19'sd131072, 19'sd131072,
           1'b1, 32'h00000000, 1'b0},
         // Rounded box with zero radius: the closed box only.
         '{MASK_ROUNDED, 16'd0, 17'd65536, 32'hFF336699, 24'h996633, 19'sd0, 19'sd65536,
           1'b0, 32'h0, 1'b0},
         '{MASK_ROUNDED, 16'd0, 17'd65536, 32'hFFFFFFFF, 24'h000000, -19'sd1, 19'sd0,
           1'b1, 32'h00000000, 1'b0},
         '{MASK_ROUNDED, 16'd0, 17'd65536, 32'hFFFFFFFF, 24'h000000, 19'sd65537, 19'sd32768,
           1'b1, 32'h00000000, 1'b0},
         // Half radius, then a corner fraction above half that saturates.
         '{MASK_ROUNDED, 16'd32768, 17'd65536, 32'hFFFFFFFF, 24'h000000, 19'sd0, 19'sd0,
           1'b1, 32'h00000000, 1'b0},
         '{MASK_ROUNDED, 16'd32768, 17'd65536, 32'hA0E01050, 24'h30C070, 19'sd32768, 19'sd0,
           1'b0, 32'h0, 1'b0},
         '{MASK_ROUNDED, 16'd65535, 17'd65536, 32'hA0E01050, 24'h30C070, 19'sd32768, 19'sd32768,
           1'b0, 32'h0, 1'b0},
         '{MASK_ROUNDED, 16'd65535, 17'd65536, 32'hFFFFFFFF, 24'h000000, 19'sd0, 19'sd0,
           1'b1, 32'h00000000, 1'b0},
         // Quarter radius: inside the corner cut and far below the box.
         '{MASK_ROUNDED, 16'd16384, 17'd65536, 32'hFF55AA55, 24'hAA55AA, 19'sd1000, 19'sd1000,
           1'b0, 32'h0, 1'b0},
         '{MASK_ROUNDED, 16'd16384, 17'd65536, 32'hFFFFFFFF, 24'h000000, 19'sd32768, -19'sd131072,
           1'b1, 32'h00000000, 1'b0}
      };

      // Reset once at the start.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, reloading registers whenever a row asks for new settings.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_cases[i];
         if (row.mode != drv_mode || row.corner != drv_corner || row.opacity != drv_opacity)
            apply_config(row.mode, row.corner, row.opacity);
         send_pixel(row.src, row.dst, row.u, row.v, row.known, row.exp_pixel, row.exp_we,
                    pick_gap());
      end

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         mode = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: corner = 16'd0;
            1: corner = 16'd32768;
            2: corner = 16'hFFFF;
            3: corner = 16'($urandom_range(32769, 65535));
            default: corner = 16'($urandom_range(1, 32767));
         endcase
         pick = $urandom_range(0, 7);
         case (pick)
            0: opacity_q = 17'd0;
            1: opacity_q = 17'd1;
            2: opacity_q = 17'd65536;
            3: opacity_q = 17'h1FFFF;
            4: opacity_q = 17'($urandom_range(65537, 131071));
            default: opacity_q = 17'($urandom_range(1, 65535));
         endcase
         apply_config(mode, corner, opacity_q);
         burst = (phase % 3 == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            src = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 10) src[31:24] = 8'h00;
            else if (pick < 20) src[31:24] = 8'hFF;
            send_pixel(src, 24'($urandom()), pick_coord(), pick_coord(), 1'b0, 32'h0, 1'b0,
                       burst ? 0 : pick_gap());
         end
      end

      // Let the pipeline empty, then keep watching for stray results before the verdict.
      drain_pipeline();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && blend_expect_q.size() == 0) begin
         $display("PASS masked_alpha_blend_pixel");
      end else begin
         $display("FAIL masked_alpha_blend_pixel");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/mab_pkg.sv
rtl/mab_mask.sv
rtl/masked_alpha_blend_pixel.sv
dv/tb_masked_alpha_blend_pixel.sv
